### sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_CPU_TICK  = 2'd1;
    localparam logic [1:0] OP_CPU_MAP   = 2'd2;
    localparam logic [1:0] OP_PPU_MAP   = 2'd3;

    localparam logic [2:0] REGION_NONE   = 3'd0;
    localparam logic [2:0] REGION_PRG    = 3'd1;
    localparam logic [2:0] REGION_OPEN   = 3'd2;
    localparam logic [2:0] REGION_CHR    = 3'd3;
    localparam logic [2:0] REGION_NTABLE = 3'd4;

    localparam logic [1:0] WR_PRG16   = 2'd0;
    localparam logic [1:0] WR_MODE    = 2'd1;
    localparam logic [1:0] WR_COUNTER = 2'd2;
    localparam logic [1:0] WR_BANKS   = 2'd3;

    localparam logic [1:0] MIRROR_VERT  = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ = 2'd1;
    localparam logic [1:0] MIRROR_PAGE0 = 2'd2;
    localparam logic [1:0] MIRROR_PAGE1 = 2'd3;

    localparam logic [0:0] CFG_CHR_ROM_SIZE = 1'd0;

    localparam logic [4:0] LAST_BANK      = 5'h1F;
    localparam logic [4:0] SECOND_LAST    = 5'h1E;
    localparam logic [6:0] CHR_2K_LIMIT   = 7'd32;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic        irq_asserted;
        logic [2:0]  region;
        logic [21:0] mapped_addr;
    } result_t;

endpackage

### sv/cbm_core.sv
// ----------------------------------------------------------------------------
// cbm_core
// Mapper state, register write decode, IRQ counter and address translation.
// State moves on each step; the result is combinational from the item.
// ----------------------------------------------------------------------------
module cbm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  cbm_pkg::item_t   item,
    input  logic [6:0]       chr_rom_size,
    output cbm_pkg::result_t result
);

    logic [7:0]  mode_reg, mode_next;
    logic [4:0]  prg_reg [4];
    logic [4:0]  prg_next [4];
    logic [7:0]  prg16_reg, prg16_next;
    logic [7:0]  chr_reg [8];
    logic [7:0]  chr_next [8];
    logic [15:0] count_reg, count_next;
    logic        irq_reg, irq_next;
    logic [4:0]  upper_lo_reg, upper_lo_next;

    logic [15:0] count_step;
    logic [7:0]  bank8;
    logic [7:0]  chr_bank;
    logic [2:0]  chr_sel;
    logic        page;
    logic [2:0]  region;
    logic [21:0] mapped;

    always_comb
    begin
        mode_next     = mode_reg;
        prg_next      = prg_reg;
        prg16_next    = prg16_reg;
        chr_next      = chr_reg;
        count_next    = count_reg;
        irq_next      = irq_reg;
        upper_lo_next = upper_lo_reg;
        count_step    = mode_reg[6] ? count_reg - 16'd1 : count_reg + 16'd1;

        case (item.op)
            cbm_pkg::OP_CPU_WRITE:
            begin
                if (item.addr[15:12] == 4'h8)
                begin
                    case (item.addr[9:8])
                        cbm_pkg::WR_PRG16:
                            prg16_next = item.data;
                        cbm_pkg::WR_MODE:
                        begin
                            mode_next = item.data;
                            irq_next  = item.data[7] && (count_reg == 16'd0);
                        end
                        cbm_pkg::WR_COUNTER:
                        begin
                            if (item.addr[0])
                                count_next = {item.data, count_reg[7:0]};
                            else
                                count_next = {count_reg[15:8], item.data};
                            irq_next = 1'b0;
                        end
                        default:
                        begin
                            if (item.addr[4])
                            begin
                                if (!item.addr[3])
                                    chr_next[item.addr[2:0]] = item.data;
                            end
                            else
                                prg_next[item.addr[1:0]] = item.data[4:0];
                        end
                    endcase
                    if (mode_next[4])
                        upper_lo_next = prg_next[2];
                    else if (!mode_next[3])
                        upper_lo_next = cbm_pkg::SECOND_LAST;
                end
            end
            cbm_pkg::OP_CPU_TICK:
            begin
                if ((count_reg != 16'd0) && mode_reg[7])
                begin
                    count_next = count_step;
                    if (count_step == 16'd0)
                        irq_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        region   = cbm_pkg::REGION_NONE;
        mapped   = 22'd0;
        bank8    = 8'd0;
        chr_sel  = item.addr[12:10];
        chr_bank = 8'd0;
        page     = 1'b0;

        case (item.op)
            cbm_pkg::OP_CPU_MAP:
            begin
                if (item.addr[15:14] == 2'b11)
                begin
                    bank8  = item.addr[13] ? {3'd0, cbm_pkg::LAST_BANK} : {3'd0, upper_lo_reg};
                    region = cbm_pkg::REGION_PRG;
                    mapped = {1'b0, bank8, item.addr[12:0]};
                end
                else if (item.addr[15])
                begin
                    region = cbm_pkg::REGION_PRG;
                    if (mode_reg[4])
                    begin
                        bank8  = {3'd0, item.addr[13] ? prg_reg[1] : prg_reg[0]};
                        mapped = {1'b0, bank8, item.addr[12:0]};
                    end
                    else
                        mapped = {prg16_reg, item.addr[13:0]};
                end
                else if (item.addr[15:13] == 3'b011)
                begin
                    if (!mode_reg[5])
                        region = cbm_pkg::REGION_OPEN;
                    else
                    begin
                        bank8  = {3'd0, mode_reg[4] ? prg_reg[3] : cbm_pkg::LAST_BANK};
                        region = cbm_pkg::REGION_PRG;
                        mapped = {1'b0, bank8, item.addr[12:0]};
                    end
                end
            end
            cbm_pkg::OP_PPU_MAP:
            begin
                if (!item.addr[13])
                begin
                    region = cbm_pkg::REGION_CHR;
                    if (chr_rom_size > cbm_pkg::CHR_2K_LIMIT)
                    begin
                        chr_sel  = {item.addr[12], item.addr[12], item.addr[11]};
                        chr_bank = chr_reg[chr_sel];
                        mapped   = {3'd0, chr_bank, item.addr[10:0]};
                    end
                    else
                    begin
                        chr_bank = chr_reg[chr_sel];
                        mapped   = {4'd0, chr_bank, item.addr[9:0]};
                    end
                end
                else
                begin
                    case (mode_reg[1:0])
                        cbm_pkg::MIRROR_VERT:  page = item.addr[10];
                        cbm_pkg::MIRROR_HORIZ: page = item.addr[11];
                        cbm_pkg::MIRROR_PAGE0: page = 1'b0;
                        default:               page = 1'b1;
                    endcase
                    region = cbm_pkg::REGION_NTABLE;
                    mapped = {11'd0, page, item.addr[9:0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.irq_asserted = irq_next;
    assign result.region       = region;
    assign result.mapped_addr  = mapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 8'd0;
            prg16_reg    <= 8'd0;
            count_reg    <= 16'd0;
            irq_reg      <= 1'b0;
            upper_lo_reg <= cbm_pkg::SECOND_LAST;
            for (int i = 0; i < 4; i++)
                prg_reg[i] <= 5'd0;
            for (int i = 0; i < 8; i++)
                chr_reg[i] <= 8'd0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            prg_reg      <= prg_next;
            prg16_reg    <= prg16_next;
            chr_reg      <= chr_next;
            count_reg    <= count_next;
            irq_reg      <= irq_next;
            upper_lo_reg <= upper_lo_next;
        end
    end

endmodule

### sv/cart_bank_mapper_with_irq_counter.sv
// ----------------------------------------------------------------------------
// cart_bank_mapper_with_irq_counter
// Cartridge bank mapper with IRQ counter: item register, mapper core,
// result register and APB configuration port.
// ----------------------------------------------------------------------------
// Path: the item is registered in the item register, translated by the
// mapper core and registered again in the result register.
// Throughput: one item per cycle while the result side does not stall; the
// mapper core updates its state as each item moves on to the result register.
// Reset: asynchronous, clears all mapper state to its reset values at once.
// ----------------------------------------------------------------------------
module cart_bank_mapper_with_irq_counter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  cbm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output cbm_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic             stage_valid_reg, stage_valid_next;
    cbm_pkg::item_t   stage_item_reg;
    logic             out_valid_reg, out_valid_next;
    cbm_pkg::result_t out_reg;
    cbm_pkg::result_t core_result;
    logic [6:0]       chr_size_reg;
    logic             advance;
    logic             load;
    logic             cfg_sel;

    assign advance    = stage_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (load)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            stage_item_reg <= item;
        if (advance)
            out_reg <= core_result;
    end

    cbm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (stage_item_reg),
        .chr_rom_size (chr_size_reg),
        .result       (core_result)
    );

    assign cfg_sel = (paddr[2] == cbm_pkg::CFG_CHR_ROM_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chr_size_reg <= 7'd0;
        else if (psel && penable && pwrite && pready && cfg_sel)
            chr_size_reg <= pwdata[6:0];
    end

    assign pready       = 1'b1;
    assign prdata       = cfg_sel ? {25'd0, chr_size_reg} : 32'd0;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### sv/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks on the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input cbm_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transfer changed");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled while result side is free");

    a_empty_regions: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.region == cbm_pkg::REGION_NONE
                         || result.region == cbm_pkg::REGION_OPEN)
        |-> result.mapped_addr == 22'd0)
        else $error("offset given for an unmapped or open-bus result");

    a_chr_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.region == cbm_pkg::REGION_CHR
        |-> result.mapped_addr[21:19] == 3'd0)
        else $error("CHR offset out of range");

    a_ntable_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.region == cbm_pkg::REGION_NTABLE
        |-> result.mapped_addr[21:11] == 11'd0)
        else $error("nametable offset out of range");

endmodule

bind cart_bank_mapper_with_irq_counter cbm_checker u_cbm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
